// ===== src/lcdx_pkg.sv =====
// Shared types and constants for the character-LCD port-expander sequencer.
package lcdx_pkg;

    typedef enum logic [1:0] {
        REQ_CMD  = 2'd0,
        REQ_DATA = 2'd1,
        REQ_GOTO = 2'd2,
        REQ_INIT = 2'd3
    } req_type_t;

    typedef enum logic {
        FR_IDLE,
        FR_INIT
    } front_state_t;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } back_state_t;

    // One byte to put on the bus in two nibbles.
    typedef struct packed {
        logic [7:0] value;
        logic       is_data;
        logic       last;
    } byte_job_t;

    localparam int unsigned INIT_COUNT = 7;
    localparam int unsigned INIT_IDX_W = $clog2(INIT_COUNT);
    localparam logic [INIT_IDX_W-1:0] INIT_LAST = INIT_IDX_W'(INIT_COUNT - 1);

    localparam logic [7:0] INIT_CMDS [INIT_COUNT] = '{
        8'h33, 8'h32, 8'h28, 8'h0E, 8'h01, 8'h06, 8'h80
    };

    localparam logic [7:0] ROW_BASE [4] = '{8'h80, 8'hC0, 8'h94, 8'hD4};

    // Byte-job queue between front and back.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Write step within a byte: bit 2 picks the nibble, bits 1..0 the phase.
    localparam logic [2:0] STEP_LAST  = 3'd7;
    localparam logic [1:0] PH_NIBBLE  = 2'd0;
    localparam logic [1:0] PH_RSRW    = 2'd1;
    localparam logic [1:0] PH_EN_HI   = 2'd2;
    localparam logic [1:0] PH_EN_LO   = 2'd3;

endpackage

// ===== src/lcdx_front.sv =====
// Request front end: classifies requests and expands them into byte jobs.
module lcdx_front import lcdx_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_byte_value,
    input  logic [4:0] s_column,
    input  logic [2:0] s_row,
    output logic       push_valid,
    output byte_job_t  push_job,
    input  logic       push_ready
);

    front_state_t          state_reg, state_next;
    logic [INIT_IDX_W-1:0] init_idx_reg, init_idx_next;
    req_type_t             req;
    logic [1:0]            row_idx;
    logic [7:0]            goto_addr;

    assign req       = req_type_t'(s_req_type);
    assign row_idx   = s_row[1:0] + 2'd3;
    assign goto_addr = ROW_BASE[row_idx] + {3'b000, s_column} - 8'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FR_IDLE;
            init_idx_reg <= '0;
        end else begin
            state_reg    <= state_next;
            init_idx_reg <= init_idx_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        init_idx_next = init_idx_reg;
        case (state_reg)
            FR_IDLE: begin
                if (s_valid && s_ready && req == REQ_INIT) begin
                    state_next    = FR_INIT;
                    init_idx_next = '0;
                end
            end
            FR_INIT: begin
                if (push_ready) begin
                    if (init_idx_reg == INIT_LAST) begin
                        state_next = FR_IDLE;
                    end else begin
                        init_idx_next = init_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = FR_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        push_valid = 1'b0;
        push_job   = '0;
        case (state_reg)
            FR_IDLE: begin
                s_ready       = push_ready;
                push_valid    = s_valid && (req != REQ_INIT);
                push_job.last = 1'b1;
                case (req)
                    REQ_CMD: begin
                        push_job.value = s_byte_value;
                    end
                    REQ_DATA: begin
                        push_job.value   = s_byte_value;
                        push_job.is_data = 1'b1;
                    end
                    REQ_GOTO: begin
                        push_job.value = goto_addr;
                    end
                    default: begin
                        push_job.value = '0;
                    end
                endcase
            end
            FR_INIT: begin
                push_valid     = 1'b1;
                push_job.value = INIT_CMDS[init_idx_reg];
                push_job.last  = (init_idx_reg == INIT_LAST);
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/lcdx_queue.sv =====
// Small register queue of byte jobs between front end and write sequencer.
module lcdx_queue import lcdx_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    input  byte_job_t push_job,
    output logic      push_ready,
    output logic      pop_valid,
    output byte_job_t pop_job,
    input  logic      pop_ready
);

    byte_job_t              mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   do_push, do_pop;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== src/lcdx_back.sv =====
// Write sequencer: turns byte jobs into eight port writes each, keeps the port shadow.
module lcdx_back import lcdx_pkg::*; #(
    parameter int unsigned RS_BIT = 0,
    parameter int unsigned RW_BIT = 1,
    parameter int unsigned EN_BIT = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       pop_valid,
    input  byte_job_t  pop_job,
    output logic       pop_ready,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_port_byte,
    output logic       m_last_write
);

    localparam logic [7:0] RS_MASK = 8'(1 << RS_BIT);
    localparam logic [7:0] RW_MASK = 8'(1 << RW_BIT);
    localparam logic [7:0] EN_MASK = 8'(1 << EN_BIT);

    back_state_t state_reg, state_next;
    byte_job_t   job_reg;
    logic [2:0]  step_reg;
    logic [7:0]  shadow_reg, shadow_next;
    logic        m_valid_reg;
    logic [7:0]  port_byte_reg;
    logic        last_reg;
    logic        advance;
    logic        load;
    logic [3:0]  nibble;

    assign advance = (state_reg == BK_RUN) && (!m_valid_reg || m_ready);
    assign load    = pop_valid && pop_ready;
    assign nibble  = step_reg[2] ? job_reg.value[3:0] : job_reg.value[7:4];

    assign m_valid      = m_valid_reg;
    assign m_port_byte  = port_byte_reg;
    assign m_last_write = last_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (pop_valid) begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN: begin
                if (advance && step_reg == STEP_LAST && !pop_valid) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        pop_ready   = 1'b0;
        shadow_next = shadow_reg;
        case (state_reg)
            BK_IDLE: begin
                pop_ready = 1'b1;
            end
            BK_RUN: begin
                pop_ready = advance && (step_reg == STEP_LAST);
            end
            default: begin
                pop_ready = 1'b0;
            end
        endcase
        case (step_reg[1:0])
            PH_NIBBLE: begin
                shadow_next = {nibble, shadow_reg[3:0]};
            end
            PH_RSRW: begin
                if (job_reg.is_data) begin
                    shadow_next = (shadow_reg | RS_MASK) & ~RW_MASK;
                end else begin
                    shadow_next = shadow_reg & ~(RS_MASK | RW_MASK);
                end
            end
            PH_EN_HI: begin
                shadow_next = shadow_reg | EN_MASK;
            end
            PH_EN_LO: begin
                shadow_next = shadow_reg & ~EN_MASK;
            end
            default: begin
                shadow_next = shadow_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            step_reg    <= '0;
            shadow_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                step_reg <= '0;
            end else if (advance) begin
                step_reg <= step_reg + 1'b1;
            end
            if (advance) begin
                shadow_reg  <= shadow_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            job_reg <= pop_job;
        end
        if (advance) begin
            port_byte_reg <= shadow_next;
            last_reg      <= job_reg.last && (step_reg == STEP_LAST);
        end
    end

endmodule

// ===== src/char_lcd_4bit_expander_sequencer_top.sv =====
// Top level of the character-LCD 4-bit port-expander write sequencer.
//
// Each accepted request transaction becomes a series of 8-bit port-expander
// writes on the m_ channel, one write per result transaction, with
// m_last_write high on the final write of the request. Command, data and
// go-to requests produce 8 writes; an init request produces 56 (seven fixed
// commands). The write sequencer emits one write per clock while m_ready is
// high and byte jobs are waiting in the queue; that single
// sequencer is what sets the rate. The front end expands each request into
// byte jobs held in a four-entry queue, so it takes the next request as soon
// as it is idle and the queue has room, while earlier bytes still drain.
// An init request holds off further requests until all seven of its jobs
// have entered the queue. The queue and the sequencer take only five at
// once, and the last two go in only as the sequencer frees room, so even
// with m_ready always high this hold lasts until it takes the third job.
// The port shadow resets to zero and persists between requests. RS_BIT,
// RW_BIT and EN_BIT place the control lines on port bits 3..0.
module char_lcd_4bit_expander_sequencer_top import lcdx_pkg::*; #(
    parameter int unsigned RS_BIT = 0,
    parameter int unsigned RW_BIT = 1,
    parameter int unsigned EN_BIT = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [7:0] s_byte_value,
    input  logic [4:0] s_column,
    input  logic [2:0] s_row,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_port_byte,
    output logic       m_last_write
);

    // Front end to queue.
    logic      push_valid;
    logic      push_ready;
    byte_job_t push_job;

    // Queue to write sequencer.
    logic      pop_valid;
    logic      pop_ready;
    byte_job_t pop_job;

    // Classify requests, compute go-to addresses, expand init.
    lcdx_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_byte_value (s_byte_value),
        .s_column     (s_column),
        .s_row        (s_row),
        .push_valid   (push_valid),
        .push_job     (push_job),
        .push_ready   (push_ready)
    );

    // Hold byte jobs so front and back stall independently.
    lcdx_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready)
    );

    // Advance the port shadow through nibble, RS/RW, EN high, EN low.
    lcdx_back #(
        .RS_BIT (RS_BIT),
        .RW_BIT (RW_BIT),
        .EN_BIT (EN_BIT)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_job      (pop_job),
        .pop_ready    (pop_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_port_byte  (m_port_byte),
        .m_last_write (m_last_write)
    );

endmodule
